/* rtl/core/skt_pkg.sv */
// Package for the sorted key table: field widths, command codes and the
// cell operation struct. Used by the request and response interfaces, the controller and the cells.
`default_nettype none

package skt_pkg;

   localparam int KEY_BITS   = 32;
   localparam int CMD_BITS   = 2;
   localparam int POS_BITS   = 7;
   localparam int COUNT_BITS = 7;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_FIND   = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_SPARE  = 2'd3
   } command_type;

   typedef struct packed {
      logic compare;
      logic signed_keys;
      logic ins;
      logic rem;
   } cell_op_type;

endpackage

`default_nettype wire

/* rtl/core/skt_req_if.sv */
// Request channel of the sorted key table: command and key with valid/ready.
// Depends on skt_pkg for field widths.
`default_nettype none

interface skt_req_if;
   logic                          valid;
   logic                          ready;
   logic [skt_pkg::CMD_BITS-1:0]  command;
   logic [skt_pkg::KEY_BITS-1:0]  key;

   modport source (output valid, output command, output key, input ready);
   modport sink   (input valid, input command, input key, output ready);
endinterface

`default_nettype wire

/* rtl/core/skt_rsp_if.sv */
// Response channel of the sorted key table: position, flags and count.
// Depends on skt_pkg for field widths.
`default_nettype none

interface skt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [skt_pkg::POS_BITS-1:0]    position;
   logic                            found;
   logic                            full_error;
   logic [skt_pkg::COUNT_BITS-1:0]  entry_count;

   modport source (output valid, output position, output found, output full_error,
                   output entry_count, input ready);
   modport sink   (input valid, input position, input found, input full_error,
                   input entry_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/skt_csr_if.sv */
// Configuration write channel of the sorted key table: the signed_keys bit.
// No dependencies.
`default_nettype none

interface skt_csr_if;
   logic valid;
   logic ready;
   logic signed_keys;

   modport source (output valid, output signed_keys, input ready);
   modport sink   (input valid, input signed_keys, output ready);
endinterface

`default_nettype wire

/* rtl/core/skt_cell.sv */
// One slot of the sorted key table: holds a key, compares it with the
// broadcast key and shifts with its neighbors. Depends on skt_pkg.
`default_nettype none

module skt_cell #(
   parameter int KEY_WIDTH = 32,
   parameter int CW        = 7,
   parameter int INDEX     = 0
) (
   input  wire logic                     clock,
   input  wire skt_pkg::cell_op_type     op,
   input  wire logic [KEY_WIDTH-1:0]     bcast_key,
   input  wire logic [CW-1:0]            count,
   input  wire logic                     at,
   input  wire logic                     pre,
   input  wire logic [KEY_WIDTH-1:0]     left_key,
   input  wire logic [KEY_WIDTH-1:0]     right_key,
   output logic      [KEY_WIDTH-1:0]     key_out,
   output logic                          sel_out,
   output logic                          eq_out
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 sel_ff, sel_in;
   logic                 eq_ff, eq_in;
   logic [KEY_WIDTH-1:0] flip;

   always_comb begin
      flip   = {op.signed_keys, {(KEY_WIDTH-1){1'b0}}};
      sel_in = sel_ff;
      eq_in  = eq_ff;
      key_in = key_ff;
      if (op.compare) begin
         sel_in = ((key_ff ^ flip) >= (bcast_key ^ flip)) && (CW'(INDEX) < count);
         eq_in  = (key_ff == bcast_key);
      end
      if (op.ins) begin
         if (at) begin
            key_in = bcast_key;
         end else if (pre) begin
            key_in = left_key;
         end
      end else if (op.rem) begin
         if (at || pre) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      sel_ff <= sel_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign sel_out = sel_ff;
   assign eq_out  = eq_ff;

endmodule

`default_nettype wire

/* rtl/core/skt_ctrl.sv */
// Sequencer of the sorted key table: takes requests and configuration,
// resolves the lower-bound slot from the cell flags, drives the cell row
// and holds the response register. Depends on skt_pkg and the channel interfaces.
`default_nettype none

module skt_ctrl #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32,
   parameter int CW        = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   skt_req_if.sink                    req,
   skt_rsp_if.source                  rsp,
   skt_csr_if.sink                    csr,
   input  wire logic [CAPACITY-1:0]   sel_vec,
   input  wire logic [CAPACITY-1:0]   eq_vec,
   output skt_pkg::cell_op_type       op,
   output logic      [KEY_WIDTH-1:0]  bcast_key,
   output logic      [CW-1:0]         count,
   output logic      [CAPACITY-1:0]   at_vec,
   output logic      [CAPACITY-1:0]   pre_vec
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_RESOLVE,
      ST_APPLY
   } state_type;

   state_type                         state_ff, state_in;
   logic [skt_pkg::CMD_BITS-1:0]      cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0]              key_ff, key_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic                              signed_ff, signed_in;
   logic [CAPACITY-1:0]               at_ff, at_in;
   logic [CAPACITY-1:0]               pre_ff;
   logic [CW-1:0]                     pos_ff, pos_in;
   logic                              found_ff, found_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [skt_pkg::POS_BITS-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic                              rsp_full_ff, rsp_full_in;
   logic [skt_pkg::COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   logic [KEY_WIDTH+skt_pkg::KEY_BITS-1:0] key_ext;
   logic [CAPACITY-1:0]               pre_comb;
   logic                              any_sel;
   logic [CW-1:0]                     pos_enc;
   logic                              advance;
   logic                              full;
   logic [CW-1:0]                     report;
   logic [CW+skt_pkg::POS_BITS-1:0]   report_ext;
   logic [CW+skt_pkg::COUNT_BITS-1:0] count_ext;

   assign key_ext = {{KEY_WIDTH{1'b0}}, req.key};
   assign any_sel = |sel_vec;

   assign pre_comb[0] = 1'b0;
   for (genvar i = 1; i < CAPACITY; i++) begin : g_pre
      assign pre_comb[i] = |sel_vec[i-1:0];
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_at
      assign at_in[i] = !pre_comb[i] && (sel_vec[i] || (!any_sel && (count_ff == CW'(i))));
   end

   always_comb begin
      pos_enc = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         pos_enc = pos_enc | (at_in[i] ? CW'(i) : CW'(0));
      end
   end

   assign advance = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp.ready);
   assign full    = (count_ff == CW'(CAPACITY));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      signed_in    = signed_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;
      report       = pos_ff;
      report_ext   = '0;
      count_ext    = '0;
      op           = '0;
      op.signed_keys = signed_ff;

      if (csr.valid) begin
         signed_in = csr.signed_keys;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               cmd_in   = req.command;
               key_in   = key_ext[KEY_WIDTH-1:0];
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            op.compare = 1'b1;
            state_in   = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            pos_in   = any_sel ? pos_enc : count_ff;
            found_in = |(sel_vec & eq_vec & ~pre_comb);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (advance) begin
               report = pos_ff;
               case (cmd_ff)
                  skt_pkg::CMD_INSERT: begin
                     if (!full) begin
                        op.ins   = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  skt_pkg::CMD_REMOVE: begin
                     if (found_ff) begin
                        op.rem   = 1'b1;
                        count_in = count_ff - CW'(1);
                     end else begin
                        report = count_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               report_ext   = {{skt_pkg::POS_BITS{1'b0}}, report};
               count_ext    = {{skt_pkg::COUNT_BITS{1'b0}}, count_in};
               rsp_valid_in = 1'b1;
               rsp_pos_in   = report_ext[skt_pkg::POS_BITS-1:0];
               rsp_found_in = found_ff;
               rsp_full_in  = (cmd_ff == skt_pkg::CMD_INSERT) && full;
               rsp_count_in = count_ext[skt_pkg::COUNT_BITS-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         signed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         signed_ff    <= signed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      if (state_ff == ST_RESOLVE) begin
         at_ff  <= at_in;
         pre_ff <= pre_comb;
      end
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req.ready       = (state_ff == ST_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.position    = rsp_pos_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.full_error  = rsp_full_ff;
   assign rsp.entry_count = rsp_count_ff;
   assign bcast_key       = key_ff;
   assign count           = count_ff;
   assign at_vec          = at_ff;
   assign pre_vec         = pre_ff;

endmodule

`default_nettype wire

/* rtl/core/sorted_key_table_top.sv */
// Top level of the sorted key table: sequencer plus a row of key cells.
// Depends on skt_pkg, the channel interfaces, skt_ctrl and skt_cell.
//
//   channel  direction  payload                                       handshake
//   req      in         command, key                                  valid/ready
//   rsp      out        position, found, full_error, entry_count      valid/ready
//   csr      in         signed_keys                                   valid/ready
//
// Each transaction runs through four steps: latch, parallel compare in every cell,
// resolve the lower-bound slot, then apply any shift and load the response.
// A new request is taken once the previous one has reached the response register.
// A stalled response holds the shift step until it is taken.
// Reset clears the count, the signed_keys bit and the response valid; no clearing pass.
`default_nettype none

module sorted_key_table_top #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   skt_req_if.sink     req_port,
   skt_rsp_if.source   rsp_port,
   skt_csr_if.sink     csr_port
);

   localparam int CW = $clog2(CAPACITY + 1);

   skt_pkg::cell_op_type    op;
   logic [KEY_WIDTH-1:0]    bcast_key;
   logic [CW-1:0]           count;
   logic [CAPACITY-1:0]     at_vec;
   logic [CAPACITY-1:0]     pre_vec;
   logic [CAPACITY-1:0]     sel_vec;
   logic [CAPACITY-1:0]     eq_vec;
   logic [KEY_WIDTH-1:0]    cell_key [CAPACITY];

   skt_ctrl #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .CW        (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_port),
      .rsp       (rsp_port),
      .csr       (csr_port),
      .sel_vec   (sel_vec),
      .eq_vec    (eq_vec),
      .op        (op),
      .bcast_key (bcast_key),
      .count     (count),
      .at_vec    (at_vec),
      .pre_vec   (pre_vec)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic [KEY_WIDTH-1:0] right_key;

      if (i == 0) begin : g_first
         assign left_key = bcast_key;
      end else begin : g_left
         assign left_key = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_right
         assign right_key = cell_key[i+1];
      end

      skt_cell #(
         .KEY_WIDTH (KEY_WIDTH),
         .CW        (CW),
         .INDEX     (i)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .bcast_key (bcast_key),
         .count     (count),
         .at        (at_vec[i]),
         .pre       (pre_vec[i]),
         .left_key  (left_key),
         .right_key (right_key),
         .key_out   (cell_key[i]),
         .sel_out   (sel_vec[i]),
         .eq_out    (eq_vec[i])
      );
   end

endmodule

`default_nettype wire

/* bench/sorted_key_table_top_tb.sv */
`timescale 1ns / 100ps
// Testbench for sorted_key_table_top: directed table walk, then random phases
// checked against an in-bench sorted table model. Depends on skt_pkg and the channel interfaces.

module sorted_key_table_top_tb;

   localparam int TABLE_DEPTH    = 64;
   localparam int PHASE_ITEMS    = 75;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PCT       = 14;

   typedef struct packed {
      logic [skt_pkg::POS_BITS-1:0]   position;
      logic                           found;
      logic                           full_error;
      logic [skt_pkg::COUNT_BITS-1:0] entry_count;
   } table_result_type;

   typedef struct packed {
      skt_pkg::command_type         cmd;
      logic [skt_pkg::KEY_BITS-1:0] key;
      logic                         sgn;
      logic                         typed;
      table_result_type             known;
   } directed_row_type;

   typedef enum {PHASE_GROW, PHASE_SHRINK, PHASE_MIX} phase_kind_type;

   localparam table_result_type NO_RESULT = '0;

   localparam directed_row_type DIRECTED_ROWS [23] = '{
      '{skt_pkg::CMD_FIND,   32'h0000_0000, 1'b0, 1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
      '{skt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b1, '{7'd0, 1'b0, 1'b0, 7'd0}},
      '{skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b1, '{7'd0, 1'b0, 1'b0, 7'd1}},
      '{skt_pkg::CMD_INSERT, 32'h0000_0000, 1'b0, 1'b1, '{7'd0, 1'b0, 1'b0, 7'd2}},
      '{skt_pkg::CMD_INSERT, 32'h8000_0000, 1'b0, 1'b1, '{7'd1, 1'b0, 1'b0, 7'd3}},
      '{skt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b1, '{7'd1, 1'b0, 1'b0, 7'd4}},
      '{skt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b1, '{7'd1, 1'b1, 1'b0, 7'd5}},
      '{skt_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 1'b0, 1'b1, '{7'd1, 1'b1, 1'b0, 7'd4}},
      '{skt_pkg::CMD_REMOVE, 32'h1234_5678, 1'b0, 1'b1, '{7'd4, 1'b0, 1'b0, 7'd4}},
      '{skt_pkg::CMD_SPARE,  32'h8000_0000, 1'b0, 1'b1, '{7'd2, 1'b1, 1'b0, 7'd4}},
      '{skt_pkg::CMD_FIND,   32'hFFFF_FFFF, 1'b0, 1'b1, '{7'd3, 1'b1, 1'b0, 7'd4}},
      '{skt_pkg::CMD_FIND,   32'h5555_5555, 1'b0, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_FIND,   32'hAAAA_AAAA, 1'b0, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_FIND,   32'h8000_0000, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_INSERT, 32'h8000_0000, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_REMOVE, 32'h7FFF_FFFF, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_FIND,   32'h0000_0000, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_INSERT, 32'h5555_5555, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_INSERT, 32'hAAAA_AAAA, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_SPARE,  32'h1234_5678, 1'b1, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_FIND,   32'h7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
      '{skt_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, NO_RESULT}
   };

   localparam phase_kind_type PHASE_PLAN [8] = '{
      PHASE_GROW, PHASE_GROW, PHASE_MIX, PHASE_SHRINK,
      PHASE_SHRINK, PHASE_GROW, PHASE_GROW, PHASE_MIX
   };
   localparam bit PHASE_SIGNED [8] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   localparam logic [skt_pkg::KEY_BITS-1:0] EDGE_KEYS [6] = '{
      32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
      32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
   };

   logic clock = 1'b0;
   logic reset;

   skt_req_if req_if ();
   skt_rsp_if rsp_if ();
   skt_csr_if csr_if ();

   sorted_key_table_top #(
      .CAPACITY  (TABLE_DEPTH),
      .KEY_WIDTH (skt_pkg::KEY_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   always #6 clock = ~clock;

   logic [skt_pkg::KEY_BITS-1:0] stored_keys [TABLE_DEPTH];
   int unsigned         stored_count = 0;
   bit                  signed_order = 1'b0;
   bit                  setting_now = 1'b0;
   table_result_type    expected_results [$];

   logic             row_typed;
   table_result_type row_known;
   bit               steady;

   int error_count    = 0;
   int request_count  = 0;
   int config_writes  = 0;
   int full_refusals  = 0;
   int key_hits       = 0;
   int quiet_cycles   = 0;

   function automatic logic [skt_pkg::KEY_BITS-1:0] order_of(
         input logic [skt_pkg::KEY_BITS-1:0] k);
      return {k[skt_pkg::KEY_BITS-1] ^ signed_order, k[skt_pkg::KEY_BITS-2:0]};
   endfunction

   task automatic apply_command(input skt_pkg::command_type cmd,
                                input logic [skt_pkg::KEY_BITS-1:0] key,
                                output table_result_type res);
      int unsigned slot;
      int unsigned reported;
      bit          hit;
      bit          refused;
      slot = stored_count;
      for (int i = 0; i < stored_count; i++) begin
         if (slot == stored_count && order_of(stored_keys[i]) >= order_of(key))
            slot = i;
      end
      hit = (slot < stored_count) && (stored_keys[slot] == key);
      reported = slot;
      refused = 1'b0;
      case (cmd)
         skt_pkg::CMD_INSERT: begin
            if (stored_count >= TABLE_DEPTH) begin
               refused = 1'b1;
            end else begin
               for (int i = stored_count; i > slot; i--)
                  stored_keys[i] = stored_keys[i-1];
               stored_keys[slot] = key;
               stored_count++;
            end
         end
         skt_pkg::CMD_REMOVE: begin
            if (hit) begin
               for (int i = slot; i + 1 < stored_count; i++)
                  stored_keys[i] = stored_keys[i+1];
               stored_count--;
            end else begin
               reported = stored_count;
            end
         end
         default: ;
      endcase
      res.position    = skt_pkg::POS_BITS'(reported);
      res.found       = hit;
      res.full_error  = refused;
      res.entry_count = skt_pkg::COUNT_BITS'(stored_count);
   endtask

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   // predict on request transactions, check on response transactions
   always @(posedge clock) begin
      table_result_type predicted;
      table_result_type wanted;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            signed_order = csr_if.signed_keys;
            config_writes++;
         end
         if (req_if.valid && req_if.ready) begin
            apply_command(skt_pkg::command_type'(req_if.command), req_if.key, predicted);
            wanted = row_typed ? row_known : predicted;
            expected_results.push_back(wanted);
            request_count++;
            if (wanted.full_error) full_refusals++;
            if (wanted.found) key_hits++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: response with none expected, expected nothing, %s",
                        $time, "actual");
               $display("   %0d/%0d/%0d/%0d", rsp_if.position, rsp_if.found,
                        rsp_if.full_error, rsp_if.entry_count);
               error_count++;
            end else begin
               wanted = expected_results.pop_front();
               compare_field("position", wanted.position, rsp_if.position);
               compare_field("found", wanted.found, rsp_if.found);
               compare_field("full_error", wanted.full_error, rsp_if.full_error);
               compare_field("entry_count", wanted.entry_count, rsp_if.entry_count);
            end
         end
      end
   end

   initial rsp_if.ready = 1'b0;
   always @(posedge clock) rsp_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[sorted_key_table_top] ERROR");
         $finish;
      end
   end

   task automatic send_request(input skt_pkg::command_type cmd,
                               input logic [skt_pkg::KEY_BITS-1:0] key,
                               input logic typed, input table_result_type known);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.key     <= key;
      row_typed      <= typed;
      row_known      <= known;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic write_signed(input bit value);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      csr_if.valid       <= 1'b1;
      csr_if.signed_keys <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      setting_now = value;
   endtask

   function automatic logic [skt_pkg::KEY_BITS-1:0] pick_key();
      int unsigned                  r;
      logic                         upper;
      logic [skt_pkg::KEY_BITS-1:0] k;
      r = $urandom_range(0, 99);
      upper = ($urandom_range(0, 1) == 1);
      if (r < 40 && stored_count > 0)
         k = stored_keys[$urandom_range(0, stored_count - 1)];
      else if (r < 55)
         k = EDGE_KEYS[$urandom_range(0, 5)];
      else if (r < 75)
         k = {{(skt_pkg::KEY_BITS-6){upper}}, 6'($urandom_range(0, 63))};
      else
         k = $urandom();
      return k;
   endfunction

   function automatic skt_pkg::command_type pick_command(input phase_kind_type kind);
      int unsigned          r;
      skt_pkg::command_type c;
      r = $urandom_range(0, 99);
      case (kind)
         PHASE_GROW:
            c = (r < 75) ? skt_pkg::CMD_INSERT : (r < 90) ? skt_pkg::CMD_FIND :
                (r < 98) ? skt_pkg::CMD_REMOVE : skt_pkg::CMD_SPARE;
         PHASE_SHRINK:
            c = (r < 70) ? skt_pkg::CMD_REMOVE : (r < 80) ? skt_pkg::CMD_INSERT :
                (r < 98) ? skt_pkg::CMD_FIND : skt_pkg::CMD_SPARE;
         default:
            c = (r < 33) ? skt_pkg::CMD_INSERT : (r < 66) ? skt_pkg::CMD_REMOVE :
                (r < 96) ? skt_pkg::CMD_FIND : skt_pkg::CMD_SPARE;
      endcase
      return c;
   endfunction

   initial begin
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.command     = skt_pkg::CMD_FIND;
      req_if.key         = '0;
      csr_if.valid       = 1'b0;
      csr_if.signed_keys = 1'b0;
      row_typed          = 1'b0;
      row_known          = NO_RESULT;
      steady             = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_signed(1'b0);

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].sgn != setting_now) write_signed(DIRECTED_ROWS[i].sgn);
         send_request(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].key, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].known);
      end

      for (int p = 0; p < 8; p++) begin
         write_signed(PHASE_SIGNED[p]);
         steady = (p == 2 || p == 5);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_request(pick_command(PHASE_PLAN[p]), pick_key(), 1'b0, NO_RESULT);
      end

      req_if.valid <= 1'b0;
      steady = 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t ns: %0d responses still expected, actual none", $time,
                  expected_results.size());
         error_count++;
      end

      $display("covered %0d requests over %0d comparison-mode writes", request_count,
               config_writes);
      $display("saw %0d full-table refusals and %0d equal-key hits, %0d failures",
               full_refusals, key_hits, error_count);
      if (error_count == 0)
         $display("[sorted_key_table_top] OK");
      else
         $display("[sorted_key_table_top] ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/core/skt_pkg.sv
rtl/core/skt_req_if.sv
rtl/core/skt_rsp_if.sv
rtl/core/skt_csr_if.sv
rtl/core/skt_cell.sv
rtl/core/skt_ctrl.sv
rtl/core/sorted_key_table_top.sv
bench/sorted_key_table_top_tb.sv
